FILE: sv/rotation_reflection_twin_detector_top_assert.svh
// Assertion macros shared by the twin detector RTL.
`ifndef ROTATION_REFLECTION_TWIN_DETECTOR_TOP_ASSERT_SVH
`define ROTATION_REFLECTION_TWIN_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RRTD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RRTD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rrtd_pkg.sv
// Constants and types of the twin detector.
package rrtd_pkg;

  localparam int BUCKETS  = 1024;
  localparam int SLOTS    = 4;
  localparam int ARM_BITS = 31;
  localparam int ARMS     = 6;

  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FILL_W = $clog2(SLOTS + 1);
  localparam int REC_DEPTH = BUCKETS * SLOTS;
  localparam int REC_AW = (REC_DEPTH > 1) ? $clog2(REC_DEPTH) : 1;
  localparam int REC_W  = ARMS * ARM_BITS;

  typedef logic [ARM_BITS-1:0] arm_t;
  typedef logic [ARMS-1:0][ARM_BITS-1:0] rec_t;

  // Bucket index: sum of the six values modulo BUCKETS (power of two).
  function automatic logic [BKT_W-1:0] bucket_of(input rec_t r);
    logic [BKT_W-1:0] acc;
    acc = '0;
    for (int j = 0; j < ARMS; j++) begin
      acc = acc + BKT_W'(r[j]);
    end
    return acc;
  endfunction

endpackage

FILE: sv/rrtd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/rrtd_cmp.sv
// Record equality under all six rotations and their reflections.
module rrtd_cmp import rrtd_pkg::*; (
  input  rec_t a,
  input  rec_t b,
  output logic hit
);

  always_comb begin
    logic [ARMS-1:0] fwd;
    logic [ARMS-1:0] rev;
    int fi;
    int ri;
    fwd = '1;
    rev = '1;
    for (int s = 0; s < ARMS; s++) begin
      for (int i = 0; i < ARMS; i++) begin
        fi = s + i;
        if (fi >= ARMS) begin
          fi = fi - ARMS;
        end
        ri = s + ARMS - i;
        if (ri >= ARMS) begin
          ri = ri - ARMS;
        end
        if (a[i] != b[fi]) begin
          fwd[s] = 1'b0;
        end
        if (a[i] != b[ri]) begin
          rev[s] = 1'b0;
        end
      end
    end
    hit = |(fwd | rev);
  end

endmodule

FILE: sv/rotation_reflection_twin_detector_top.sv
// Top level of the rotation/reflection twin detector.
//
// Give one six-value record with start while busy is low; the record hashes
// to a bucket (sum of its values modulo BUCKETS) and is compared against
// every stored record of that bucket under all rotations and reflections.
// One record passes from accept through the bucket fill-count read, a scan
// reading each slot in turn on the single read port of the record memory,
// and write-back. The result word shows in the cycle after write-back, and
// busy drops in that same cycle, so a new word is accepted only once the
// previous result shows. The result word appears for exactly one cycle
// with out_valid; there is no way to stall it, so sample it when it shows.
// After reset busy stays high while a clearing pass zeroes the fill counts.
// A record that lands in a full bucket is still compared but not stored,
// and out_dropped reports it.
`include "rotation_reflection_twin_detector_top_assert.svh"

module rotation_reflection_twin_detector_top import rrtd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [ARM_BITS-1:0] in_arm0,
  input  logic [ARM_BITS-1:0] in_arm1,
  input  logic [ARM_BITS-1:0] in_arm2,
  input  logic [ARM_BITS-1:0] in_arm3,
  input  logic [ARM_BITS-1:0] in_arm4,
  input  logic [ARM_BITS-1:0] in_arm5,
  output logic                out_valid,
  output logic                out_match_now,
  output logic                out_twin_seen,
  output logic                out_dropped
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_FILL  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_WRITE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [BKT_W-1:0]    clr_r, clr_nxt;
  logic [BKT_W-1:0]    bucket_r, bucket_nxt;
  rec_t                rec_r, rec_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [SLOT_W-1:0]   k_r, k_nxt;
  logic                match_r, match_nxt;
  logic                twin_r, twin_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_match_r, out_match_nxt;
  logic                out_drop_r, out_drop_nxt;

  rec_t                in_rec;
  logic                accept;
  logic                room;
  logic                hit;

  // Fill-count memory ports.
  logic                fill_we;
  logic [BKT_W-1:0]    fill_waddr;
  logic [FILL_W-1:0]   fill_wdata;
  logic [BKT_W-1:0]    fill_raddr;
  logic [FILL_W-1:0]   fill_rdata;

  // Record memory ports.
  logic                rec_we;
  logic [REC_AW-1:0]   rec_waddr;
  logic [REC_AW-1:0]   rec_raddr;
  logic [SLOT_W-1:0]   rd_k;
  rec_t                rec_rdata;

  assign in_rec = {in_arm5, in_arm4, in_arm3, in_arm2, in_arm1, in_arm0};
  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign room   = (fill_r < FILL_W'(SLOTS));

  rrtd_ram #(.WIDTH(FILL_W), .DEPTH(BUCKETS)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .raddr (fill_raddr),
    .rdata (fill_rdata)
  );

  rrtd_ram #(.WIDTH(REC_W), .DEPTH(REC_DEPTH)) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_r),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  rrtd_cmp u_cmp (
    .a   (rec_r),
    .b   (rec_rdata),
    .hit (hit)
  );

  // The fill count is read straight from the input ports in the accept cycle.
  assign fill_raddr = bucket_of(in_rec);

  // Prefetch slot 0 during the fill read, then one slot ahead while scanning.
  always_comb begin
    if (state_r == ST_SCAN && k_r != SLOT_W'(SLOTS - 1)) begin
      rd_k = k_r + SLOT_W'(1);
    end else begin
      rd_k = '0;
    end
  end

  assign rec_raddr = REC_AW'(bucket_r) * REC_AW'(SLOTS) + REC_AW'(rd_k);
  assign rec_waddr = REC_AW'(bucket_r) * REC_AW'(SLOTS) + REC_AW'(fill_r);

  // Write-back: either the clearing sweep or the incremented count.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      fill_we    = 1'b1;
      fill_waddr = clr_r;
      fill_wdata = '0;
    end else begin
      fill_we    = (state_r == ST_WRITE) && room;
      fill_waddr = bucket_r;
      fill_wdata = fill_r + FILL_W'(1);
    end
  end

  assign rec_we = (state_r == ST_WRITE) && room;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    bucket_nxt    = bucket_r;
    rec_nxt       = rec_r;
    fill_nxt      = fill_r;
    k_nxt         = k_r;
    match_nxt     = match_r;
    twin_nxt      = twin_r;
    out_valid_nxt = 1'b0;
    out_match_nxt = out_match_r;
    out_drop_nxt  = out_drop_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + BKT_W'(1);
        if (clr_r == BKT_W'(BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          rec_nxt    = in_rec;
          bucket_nxt = fill_raddr;
          match_nxt  = 1'b0;
          state_nxt  = ST_FILL;
        end
      end
      ST_FILL: begin
        // Clamp the count to the slot limit.
        if (fill_rdata > FILL_W'(SLOTS)) begin
          fill_nxt = FILL_W'(SLOTS);
        end else begin
          fill_nxt = fill_rdata;
        end
        k_nxt     = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        // Only slots below the fill count hold written records.
        if (hit && (FILL_W'(k_r) < fill_r)) begin
          match_nxt = 1'b1;
        end
        k_nxt = k_r + SLOT_W'(1);
        if (k_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        twin_nxt      = twin_r | match_r;
        out_valid_nxt = 1'b1;
        out_match_nxt = match_r;
        out_drop_nxt  = !room;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      match_r     <= 1'b0;
      twin_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      match_r     <= match_nxt;
      twin_r      <= twin_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bucket_r    <= bucket_nxt;
    rec_r       <= rec_nxt;
    fill_r      <= fill_nxt;
    k_r         <= k_nxt;
    out_match_r <= out_match_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_match_now = out_match_r;
  assign out_twin_seen = twin_r;
  assign out_dropped   = out_drop_r;

  `RRTD_ASSERT_NXT(a_accept_reads_fill, accept, state_r == ST_FILL,
                   "accepted record did not start the fill read")
  `RRTD_ASSERT_IMP(a_match_sets_twin, out_valid_r && out_match_r, twin_r,
                   "match reported without sticky twin flag")
  `RRTD_ASSERT_IMP(a_fill_bounded, fill_we, fill_wdata <= FILL_W'(SLOTS),
                   "bucket fill count written beyond slot limit")
  `RRTD_ASSERT_IMP(a_result_when_idle, out_valid_r, state_r == ST_IDLE,
                   "result strobe outside idle state")

endmodule
